@@ rtl/gchg_pkg.sv @@
// gchg_pkg: shared widths, reset values, command codes and the
// controller/datapath interface types of the greedy change dispenser
// no dependencies
`default_nettype none

package gchg_pkg;

  localparam int unsigned NUM_SLOTS    = 5;
  localparam int unsigned SLOT_WIDTH   = 3;
  localparam int unsigned VALUE_WIDTH  = 16;
  localparam int unsigned AMOUNT_WIDTH = 16;
  localparam int unsigned STOCK_WIDTH  = 8;
  localparam int unsigned CNT_WIDTH    = $clog2(AMOUNT_WIDTH);

  localparam logic [SLOT_WIDTH-1:0] LAST_SLOT      = SLOT_WIDTH'(NUM_SLOTS - 1);
  localparam logic [CNT_WIDTH-1:0]  LAST_DIV_STEP  = CNT_WIDTH'(AMOUNT_WIDTH - 1);

  // command field codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_CHANGE = 1'b1;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  localparam value_t SLOT_VALUE_RESET [NUM_SLOTS] = '{
    value_t'(100), value_t'(25), value_t'(10), value_t'(5), value_t'(1)
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_ACK,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_CLAMP,
    ST_MUL,
    ST_EMIT
  } gchg_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // load word accepted: write stock, latch slot
    logic start;      // change word accepted: latch amount, slot 0
    logic div_init;   // set up quotient for current slot
    logic div_step;   // one quotient bit
    logic clamp;      // pick coin count, update stock
    logic mul;        // register count times value
    logic emit_slot;  // update totals, write one slot result
    logic emit_load;  // write load acknowledge
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;   // final quotient bit this cycle
    logic slot_last;  // working on the last slot
    logic out_free;   // output register can take a word
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/greedy_change_dispenser.sv @@
// greedy_change_dispenser: top level, joins the controller and datapath
// depends on gchg_pkg, gchg_ctrl, gchg_dp
//
// usage
//   input channel (in_valid / in_stall): one word per command. command
//   load sets the stock count of slot_index to stock_value and answers with
//   one acknowledge word; command change pays out amount_requested slot by
//   slot, slot 0 first through slot 4, and answers with five
//   words, one per slot, the fifth marked by last_result.
//   output channel (out_valid / out_stall): one registered word at a time;
//   while out_stall is high the word holds and the sequencer waits before
//   writing the next word, so no word is lost.
//   config channel (cfg_valid / cfg_ready): slot coin values, index 0..4,
//   ready is always high; write only while the block is idle.
//   sequence: a load acknowledge is written as soon as the output register
//   is free. a change runs these steps per slot: 1 setup, 16 quotient steps
//   in the shared bit-serial divider, 1 clamp, 1 multiply, 1 output write;
//   a new word is taken once the last result has been written into the
//   output register.
//   reset: slot values return to 100, 25, 10, 5, 1 cents, all stock counts
//   clear to zero, output register empties.
`default_nettype none

module greedy_change_dispenser (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  command,
  input  wire  [gchg_pkg::SLOT_WIDTH-1:0]      slot_index,
  input  wire  [gchg_pkg::STOCK_WIDTH-1:0]     stock_value,
  input  wire  [gchg_pkg::AMOUNT_WIDTH-1:0]    amount_requested,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [gchg_pkg::SLOT_WIDTH-1:0]      slot_out,
  output logic [gchg_pkg::STOCK_WIDTH-1:0]     coins_used,
  output logic [gchg_pkg::AMOUNT_WIDTH-1:0]    amount_given,
  output logic                                 incomplete,
  output logic                                 last_result,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [gchg_pkg::SLOT_WIDTH-1:0]      cfg_index,
  input  wire  [gchg_pkg::VALUE_WIDTH-1:0]     cfg_data
);
  import gchg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // config registers are plain flops, always writable
  assign cfg_ready = 1'b1;

  // sequencer: accepts a word only when idle, steps the datapath
  gchg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // slot values, stock counts, divider, multiplier, output register
  gchg_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .slot_index       (slot_index),
    .stock_value      (stock_value),
    .amount_requested (amount_requested),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .slot_out         (slot_out),
    .coins_used       (coins_used),
    .amount_given     (amount_given),
    .incomplete       (incomplete),
    .last_result      (last_result)
  );

endmodule

`default_nettype wire

@@ rtl/gchg_ctrl.sv @@
// gchg_ctrl: sequencing state machine of the greedy change dispenser
// depends on gchg_pkg
`default_nettype none

module gchg_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  command,
  output logic                 in_stall,
  input  gchg_pkg::dp_status_t status,
  output gchg_pkg::dp_cmd_t    cmd
);
  import gchg_pkg::*;

  gchg_state_t state;
  gchg_state_t state_next;
  logic        accept;

  assign accept = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (command == CMD_CHANGE) ? ST_DIV_INIT : ST_LOAD_ACK;
        end
      end
      ST_LOAD_ACK: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV_INIT: state_next = ST_DIV_STEP;
      ST_DIV_STEP: begin
        if (status.div_last) begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: state_next = ST_MUL;
      ST_MUL:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = status.slot_last ? ST_IDLE : ST_DIV_INIT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.load  = accept && (command == CMD_LOAD);
        cmd.start = accept && (command == CMD_CHANGE);
      end
      ST_LOAD_ACK: cmd.emit_load = status.out_free;
      ST_DIV_INIT: cmd.div_init  = 1'b1;
      ST_DIV_STEP: cmd.div_step  = 1'b1;
      ST_CLAMP:    cmd.clamp     = 1'b1;
      ST_MUL:      cmd.mul       = 1'b1;
      ST_EMIT:     cmd.emit_slot = status.out_free;
      default:     cmd           = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/gchg_dp.sv @@
// gchg_dp: datapath of the greedy change dispenser: slot values, stock
// counts, bit-serial quotient, coin count and product, output register
// depends on gchg_pkg
`default_nettype none

module gchg_dp (
  input  wire                                  clk,
  input  wire                                  rst,
  input  gchg_pkg::dp_cmd_t                    cmd,
  output gchg_pkg::dp_status_t                 status,
  input  wire                                  cfg_we,
  input  wire  [gchg_pkg::SLOT_WIDTH-1:0]      cfg_index,
  input  wire  [gchg_pkg::VALUE_WIDTH-1:0]     cfg_data,
  input  wire  [gchg_pkg::SLOT_WIDTH-1:0]      slot_index,
  input  wire  [gchg_pkg::STOCK_WIDTH-1:0]     stock_value,
  input  wire  [gchg_pkg::AMOUNT_WIDTH-1:0]    amount_requested,
  input  wire                                  out_stall,
  output logic                                 out_valid,
  output logic [gchg_pkg::SLOT_WIDTH-1:0]      slot_out,
  output logic [gchg_pkg::STOCK_WIDTH-1:0]     coins_used,
  output logic [gchg_pkg::AMOUNT_WIDTH-1:0]    amount_given,
  output logic                                 incomplete,
  output logic                                 last_result
);
  import gchg_pkg::*;

  value_t                         slot_value [NUM_SLOTS];
  logic [STOCK_WIDTH-1:0]         coin_stock [NUM_SLOTS];

  logic [SLOT_WIDTH-1:0]          slot;
  logic [SLOT_WIDTH-1:0]          load_slot;
  logic [AMOUNT_WIDTH-1:0]        remaining;
  logic [AMOUNT_WIDTH-1:0]        given;
  logic [AMOUNT_WIDTH-1:0]        quot;
  logic [VALUE_WIDTH-1:0]         part_rem;
  logic [CNT_WIDTH-1:0]           div_cnt;
  logic [STOCK_WIDTH-1:0]         coins;
  logic [AMOUNT_WIDTH-1:0]        prod;

  value_t                         cur_value;
  logic [STOCK_WIDTH-1:0]         cur_stock;
  logic [VALUE_WIDTH:0]           shifted;
  logic [VALUE_WIDTH:0]           trial;
  logic [STOCK_WIDTH-1:0]         coins_next;
  logic [STOCK_WIDTH+VALUE_WIDTH-1:0] prod_full;
  logic [AMOUNT_WIDTH-1:0]        remaining_next;
  logic [AMOUNT_WIDTH-1:0]        given_next;

  assign cur_value = slot_value[slot];
  assign cur_stock = coin_stock[slot];

  // restoring division, one quotient bit per cycle
  assign shifted = {part_rem, quot[AMOUNT_WIDTH-1]};
  assign trial   = shifted - {1'b0, cur_value};

  // zero-valued slot empties itself while anything is still owed
  always_comb begin
    if (cur_value == '0) begin
      coins_next = (remaining != '0) ? cur_stock : '0;
    end else if (quot < AMOUNT_WIDTH'(cur_stock)) begin
      coins_next = quot[STOCK_WIDTH-1:0];
    end else begin
      coins_next = cur_stock;
    end
  end

  assign prod_full      = coins * cur_value;
  assign remaining_next = remaining - prod;
  assign given_next     = given + prod;

  assign status.div_last  = (div_cnt == LAST_DIV_STEP);
  assign status.slot_last = (slot == LAST_SLOT);
  assign status.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_value[i] <= SLOT_VALUE_RESET[i];
        coin_stock[i] <= '0;
      end
    end else begin
      if (cfg_we && (cfg_index <= LAST_SLOT)) begin
        slot_value[cfg_index] <= cfg_data;
      end
      if (cmd.load && (slot_index <= LAST_SLOT)) begin
        coin_stock[slot_index] <= stock_value;
      end
      if (cmd.clamp) begin
        coin_stock[slot] <= cur_stock - coins_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      load_slot <= slot_index;
    end
    if (cmd.start) begin
      remaining <= amount_requested;
      given     <= '0;
      slot      <= '0;
    end
    if (cmd.div_init) begin
      quot     <= remaining;
      part_rem <= '0;
      div_cnt  <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[VALUE_WIDTH]) begin
        part_rem <= trial[VALUE_WIDTH-1:0];
        quot     <= {quot[AMOUNT_WIDTH-2:0], 1'b1};
      end else begin
        part_rem <= shifted[VALUE_WIDTH-1:0];
        quot     <= {quot[AMOUNT_WIDTH-2:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.clamp) begin
      coins <= coins_next;
    end
    if (cmd.mul) begin
      prod <= AMOUNT_WIDTH'(prod_full);
    end
    if (cmd.emit_slot) begin
      remaining <= remaining_next;
      given     <= given_next;
      slot      <= slot + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_slot || cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_slot) begin
      slot_out     <= slot;
      coins_used   <= coins;
      amount_given <= given_next;
      incomplete   <= status.slot_last && (remaining_next != '0);
      last_result  <= status.slot_last;
    end else if (cmd.emit_load) begin
      slot_out     <= load_slot;
      coins_used   <= '0;
      amount_given <= '0;
      incomplete   <= (load_slot > LAST_SLOT);
      last_result  <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/gchg_checker.sv @@
// gchg_checker: port-level assertions for the greedy change dispenser,
// bound to the top level; depends on gchg_pkg
`default_nettype none

module gchg_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               out_valid,
  input wire                               out_stall,
  input wire [gchg_pkg::SLOT_WIDTH-1:0]    slot_out,
  input wire [gchg_pkg::STOCK_WIDTH-1:0]   coins_used,
  input wire [gchg_pkg::AMOUNT_WIDTH-1:0]  amount_given,
  input wire                               incomplete,
  input wire                               last_result
);
  import gchg_pkg::*;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(slot_out) &&
      $stable(coins_used) && $stable(amount_given) &&
      $stable(incomplete) && $stable(last_result))
    else $error("stalled output word changed");

  // only the final word may flag a short payout
  a_incomplete_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |-> !incomplete)
    else $error("incomplete set on a non-final word");

  // non-final words come from slots before the last one
  a_slot_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |-> slot_out < LAST_SLOT)
    else $error("non-final word from the last slot or beyond");

  // out-of-range slot only in a flagged load acknowledge
  a_bad_slot_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && (slot_out > LAST_SLOT) |->
      incomplete && last_result && (coins_used == '0) && (amount_given == '0))
    else $error("bad slot acknowledge malformed");

endmodule

bind greedy_change_dispenser gchg_checker u_gchg_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .slot_out     (slot_out),
  .coins_used   (coins_used),
  .amount_given (amount_given),
  .incomplete   (incomplete),
  .last_result  (last_result)
);

`default_nettype wire

@@ test/gchg_payout_check.sv @@
// gchg_payout_check: watches the input, output and config channels of the
// greedy change dispenser, predicts every result word and compares it
// depends on gchg_pkg
module gchg_payout_check
  import gchg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    command,
  input  logic [SLOT_WIDTH-1:0]   slot_index,
  input  logic [STOCK_WIDTH-1:0]  stock_value,
  input  logic [AMOUNT_WIDTH-1:0] amount_requested,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [SLOT_WIDTH-1:0]   slot_out,
  input  logic [STOCK_WIDTH-1:0]  coins_used,
  input  logic [AMOUNT_WIDTH-1:0] amount_given,
  input  logic                    incomplete,
  input  logic                    last_result,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [SLOT_WIDTH-1:0]   cfg_index,
  input  logic [VALUE_WIDTH-1:0]  cfg_data,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic [SLOT_WIDTH-1:0]   slot;
    logic [STOCK_WIDTH-1:0]  coins;
    logic [AMOUNT_WIDTH-1:0] given;
    logic                    unpaid;
    logic                    last;
  } payout_t;

  value_t                 coin_value  [NUM_SLOTS];
  logic [STOCK_WIDTH-1:0] stock_count [NUM_SLOTS];
  payout_t                payouts_due [$];

  // load: one ack word, out-of-range slot gets the error mark
  function automatic void load_slot(input logic [SLOT_WIDTH-1:0] slot,
                                    input logic [STOCK_WIDTH-1:0] count);
    payout_t p;
    p = '{slot: slot, coins: '0, given: '0, unpaid: 1'b0, last: 1'b1};
    if (slot < NUM_SLOTS) stock_count[slot] = count;
    else p.unpaid = 1'b1;
    payouts_due.push_back(p);
  endfunction

  // change: greedy pass over the slots in order, limited by stock
  function automatic void dispense(input logic [AMOUNT_WIDTH-1:0] amount);
    logic [AMOUNT_WIDTH-1:0] remaining;
    logic [AMOUNT_WIDTH-1:0] total;
    int unsigned             quot;
    int unsigned             take;
    int unsigned             paid;
    payout_t                 p;
    remaining = amount;
    total     = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (coin_value[i] == '0) begin
        // worthless coin: drains the slot while anything is still owed
        take = (remaining != '0) ? stock_count[i] : 0;
      end else begin
        quot = remaining / coin_value[i];
        take = (quot < stock_count[i]) ? quot : stock_count[i];
      end
      paid           = take * coin_value[i];
      stock_count[i] = STOCK_WIDTH'(stock_count[i] - take);
      remaining      = AMOUNT_WIDTH'(remaining - paid);
      total          = AMOUNT_WIDTH'(total + paid);
      p.slot   = SLOT_WIDTH'(i);
      p.coins  = STOCK_WIDTH'(take);
      p.given  = total;
      p.last   = (i == NUM_SLOTS - 1);
      p.unpaid = p.last && (remaining != '0);
      payouts_due.push_back(p);
    end
  endfunction

  always @(posedge clk) begin
    payout_t got;
    payout_t want;
    got = '{slot: slot_out, coins: coins_used, given: amount_given,
            unpaid: incomplete, last: last_result};
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        coin_value[i]  = SLOT_VALUE_RESET[i];
        stock_count[i] = '0;
      end
      payouts_due.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NUM_SLOTS) coin_value[cfg_index] = cfg_data;
      // outputs first: a word leaving now never belongs to a word entering now
      if (out_valid && !out_stall) begin
        if (payouts_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: slot %0d coins %0d given %0d incomplete %b last %b",
                     got.slot, got.coins, got.given, got.unpaid, got.last);
        end else begin
          want = payouts_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"payout mismatch: expected slot %0d coins %0d given %0d ",
                        "incomplete %b last %b, got slot %0d coins %0d given %0d ",
                        "incomplete %b last %b"},
                       want.slot, want.coins, want.given, want.unpaid, want.last,
                       got.slot, got.coins, got.given, got.unpaid, got.last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (command == CMD_LOAD) load_slot(slot_index, stock_value);
        else dispense(amount_requested);
      end
    end
    pending <= payouts_due.size();
  end

endmodule

@@ test/greedy_change_dispenser_test.sv @@
// greedy_change_dispenser_test: drives loads, change requests and coin value
// writes into the dispenser with random gaps and stalls, gives the verdict
// depends on gchg_pkg, greedy_change_dispenser, gchg_payout_check
module greedy_change_dispenser_test;

  import gchg_pkg::*;

  // cycles to let pass once nothing is expected
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 150;
  localparam int CYCLE_LIMIT   = 200000;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic                    command;
  logic [SLOT_WIDTH-1:0]   slot_index;
  logic [STOCK_WIDTH-1:0]  stock_value;
  logic [AMOUNT_WIDTH-1:0] amount_requested;
  logic                    out_valid;
  logic                    out_stall;
  logic [SLOT_WIDTH-1:0]   slot_out;
  logic [STOCK_WIDTH-1:0]  coins_used;
  logic [AMOUNT_WIDTH-1:0] amount_given;
  logic                    incomplete;
  logic                    last_result;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [SLOT_WIDTH-1:0]   cfg_index;
  logic [VALUE_WIDTH-1:0]  cfg_data;

  int errors;
  int pending;
  int cycle_count = 0;

  // knobs shared by the sender and the receiver
  int gap_max     = 8;   // sender: largest idle gap before a word
  int stall_max   = 8;   // receiver: largest stall before a word
  int hold_cycles = 0;   // receiver: one long hold-off when set

  greedy_change_dispenser dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .slot_index       (slot_index),
    .stock_value      (stock_value),
    .amount_requested (amount_requested),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .slot_out         (slot_out),
    .coins_used       (coins_used),
    .amount_given     (amount_given),
    .incomplete       (incomplete),
    .last_result      (last_result),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  gchg_payout_check payout_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .slot_index       (slot_index),
    .stock_value      (stock_value),
    .amount_requested (amount_requested),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .slot_out         (slot_out),
    .coins_used       (coins_used),
    .amount_given     (amount_given),
    .incomplete       (incomplete),
    .last_result      (last_result),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .errors           (errors),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stall before each word, one long hold-off on request
  initial begin
    int wait_cycles;
    out_stall <= 1'b0;
    @(posedge clk);
    wait (rst == 1'b0);
    forever begin
      if (hold_cycles > 0) begin
        wait_cycles = hold_cycles;
        hold_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(stall_max, 0);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      // stall is low from here on, so the next valid edge takes a word
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // one input word: optional idle gap, then hold it until taken;
  // with no gap valid simply stays high for back-to-back words
  task automatic send_word(input logic                    cmd,
                           input logic [SLOT_WIDTH-1:0]   slot,
                           input logic [STOCK_WIDTH-1:0]  count,
                           input logic [AMOUNT_WIDTH-1:0] amount);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command          <= cmd;
    slot_index       <= slot;
    stock_value      <= count;
    amount_requested <= amount;
    in_valid         <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // fields that a command ignores carry random bits
  task automatic load_stock(input logic [SLOT_WIDTH-1:0] slot,
                            input logic [STOCK_WIDTH-1:0] count);
    send_word(CMD_LOAD, slot, count, AMOUNT_WIDTH'($urandom));
  endtask

  task automatic make_change(input logic [AMOUNT_WIDTH-1:0] amount);
    send_word(CMD_CHANGE, SLOT_WIDTH'($urandom), STOCK_WIDTH'($urandom), amount);
  endtask

  // drop valid and wait until every expected word has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all five coin values, written back to back while the block is idle
  task automatic write_coin_values(input value_t v0, input value_t v1, input value_t v2,
                                   input value_t v3, input value_t v4);
    value_t vals [NUM_SLOTS];
    vals = '{v0, v1, v2, v3, v4};
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cfg_index <= SLOT_WIDTH'(i);
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [STOCK_WIDTH-1:0] pick_stock();
    case ($urandom_range(3, 0))
      0:       return '0;
      1:       return '1;
      2:       return STOCK_WIDTH'($urandom_range(12, 0));
      default: return STOCK_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [AMOUNT_WIDTH-1:0] pick_amount();
    case ($urandom_range(4, 0))
      0:       return AMOUNT_WIDTH'($urandom_range(300, 0));
      1:       return AMOUNT_WIDTH'($urandom_range(3000, 0));
      2:       return AMOUNT_WIDTH'($urandom);
      3:       return ($urandom_range(1, 0) == 0) ? '0 : '1;
      default: return AMOUNT_WIDTH'($urandom_range(60, 1));
    endcase
  endfunction

  // random mix of restocks and payouts; a few loads aim past the last slot
  task automatic random_words(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 5) load_stock(SLOT_WIDTH'($urandom_range(7, 5)), pick_stock());
      else if (pick < 50) load_stock(SLOT_WIDTH'($urandom_range(4, 0)), pick_stock());
      else make_change(pick_amount());
    end
  endtask

  initial begin
    rst              <= 1'b1;
    in_valid         <= 1'b0;
    command          <= CMD_LOAD;
    slot_index       <= '0;
    stock_value      <= '0;
    amount_requested <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed, reset coin values 100 25 10 5 1
    make_change('0);            // nothing owed, nothing in stock
    make_change(AMOUNT_WIDTH'(1));   // empty machine cannot pay
    load_stock(SLOT_WIDTH'(5), '1);  // slots past the last one only flag an error
    load_stock(SLOT_WIDTH'(6), '0);
    load_stock(SLOT_WIDTH'(7), STOCK_WIDTH'(8'h5a));
    load_stock(SLOT_WIDTH'(0), '1);
    load_stock(SLOT_WIDTH'(1), STOCK_WIDTH'(2));
    load_stock(SLOT_WIDTH'(2), '1);
    load_stock(SLOT_WIDTH'(3), '0);
    load_stock(SLOT_WIDTH'(4), '1);
    make_change('1);            // largest amount, empties every stocked slot, slot 0 pays the most
    make_change('0);
    make_change(AMOUNT_WIDTH'(289));  // stock is used up, nothing is paid
    make_change(AMOUNT_WIDTH'(7));    // still nothing in stock, nothing is paid
    load_stock(SLOT_WIDTH'(4), '0);
    make_change(AMOUNT_WIDTH'(3));    // short payout
    settle();
    random_words(25);
    settle();

    // extreme coin values, no idling on either side
    gap_max   = 0;
    stall_max = 0;
    write_coin_values('1, value_t'(1), '1, value_t'(1), '1);
    random_words(15);
    gap_max   = 8;
    stall_max = 8;
    random_words(15);
    settle();

    // worthless coins: a slot of value zero empties itself while money is owed
    write_coin_values('0, value_t'(50), '0, value_t'(3), value_t'(1));
    load_stock(SLOT_WIDTH'(0), STOCK_WIDTH'(4));
    load_stock(SLOT_WIDTH'(2), STOCK_WIDTH'(9));
    load_stock(SLOT_WIDTH'(1), STOCK_WIDTH'(2));
    make_change('0);
    make_change(AMOUNT_WIDTH'(130));
    random_words(25);
    settle();

    // random, roughly descending coin values
    write_coin_values(value_t'($urandom_range(2000, 200)), value_t'($urandom_range(199, 30)),
                      value_t'($urandom_range(29, 7)), value_t'($urandom_range(6, 2)),
                      value_t'($urandom_range(3, 1)));
    random_words(30);
    settle();

    // back to the usual coins; receiver holds off while words pile up
    write_coin_values(value_t'(100), value_t'(25), value_t'(10), value_t'(5), value_t'(1));
    gap_max     = 0;
    hold_cycles = 600;
    for (int i = 0; i < 8; i++) load_stock(SLOT_WIDTH'(i % NUM_SLOTS), pick_stock());
    make_change(pick_amount());
    gap_max = 8;
    random_words(20);
    settle();

    // anything that shows up now is a stray word
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/gchg_pkg.sv
rtl/gchg_ctrl.sv
rtl/gchg_dp.sv
rtl/greedy_change_dispenser.sv
rtl/gchg_checker.sv
test/gchg_payout_check.sv
test/greedy_change_dispenser_test.sv
